// ----- rtl/isbo_pkg.sv -----
// ----------------------------------------------------------------------------
// isbo_pkg
// Shared types and constants for the integer stack with bottom operations.
// ----------------------------------------------------------------------------
package isbo_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned TYPE_W    = 3;
	localparam int unsigned POS_W     = 5;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned COUNT_W   = 5;
	localparam int unsigned DEPTH_DEF = 16;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [TYPE_W-1:0] {
		REQ_PUSH      = 3'd0,
		REQ_POP       = 3'd1,
		REQ_INSERT    = 3'd2,
		REQ_RM_BOTTOM = 3'd3,
		REQ_RM_POS    = 3'd4,
		REQ_ZERO_EVEN = 3'd5,
		REQ_QUERY     = 3'd6
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// per-cycle command broadcast to every cell
	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_WRITE_AT,
		CMD_INSERT,
		CMD_SHIFT_DOWN,
		CMD_ZERO_EVEN
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		word_t     word;
	} cell_ctl_t;

endpackage

// ----- rtl/isbo_req_if.sv -----
// ----------------------------------------------------------------------------
// isbo_req_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
interface isbo_req_if
	import isbo_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [TYPE_W-1:0]  req_type;
	word_t              value;
	logic [POS_W-1:0]   position;

	modport source (output valid, output req_type, output value, output position,
		input ready);
	modport sink (input valid, input req_type, input value, input position,
		output ready);
endinterface

// ----- rtl/isbo_rsp_if.sv -----
// ----------------------------------------------------------------------------
// isbo_rsp_if
// Response channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface isbo_rsp_if
	import isbo_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [COUNT_W-1:0]   count;
	word_t                top_value;
	logic                 top_valid;
	word_t                removed_value;

	modport source (output valid, output status, output count, output top_value,
		output top_valid, output removed_value, input ready);
	modport sink (input valid, input status, input count, input top_value,
		input top_valid, input removed_value, output ready);
endinterface

// ----- rtl/isbo_cell.sv -----
// ----------------------------------------------------------------------------
// isbo_cell
// One stack slot; loads from itself, its neighbors or the broadcast word.
// ----------------------------------------------------------------------------
module isbo_cell
	import isbo_pkg::*;
#(
	parameter int unsigned INDEX = 0,
	parameter int unsigned CW    = 5
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [CW-1:0] count,
	input  logic [CW-1:0] from_idx,
	input  word_t         left_word,
	input  word_t         right_word,
	output word_t         word,
	output word_t         next_word
);

	localparam logic [CW-1:0] IDX      = CW'(INDEX);
	localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

	word_t word_q;
	word_t d;

	always_comb begin
		d = word_q;
		case (ctl.cmd)
			CMD_WRITE_AT: begin
				if (count == IDX) d = ctl.word;
			end
			CMD_INSERT: begin
				if (INDEX == 0) d = ctl.word;
				else if (IDX <= count) d = left_word;
			end
			CMD_SHIFT_DOWN: begin
				if (IDX >= from_idx && IDX_NEXT < count) d = right_word;
			end
			CMD_ZERO_EVEN: begin
				if (IDX < count && !word_q[0]) d = '0;
			end
			default: d = word_q;
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= d;
	end

	assign word      = word_q;
	assign next_word = d;

endmodule

// ----- rtl/integer_stack_with_bottom_ops_unit.sv -----
// ----------------------------------------------------------------------------
// integer_stack_with_bottom_ops_unit
// Bounded stack of signed words built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req: one word per request: req_type, value, position (1 = bottom entry).
//   rsp: one word per request: status, count, top_value, top_valid and
//        removed_value, in request order.
//   The response is valid in the cycle after accept. Throughput is one
//   request per cycle while the receiver keeps up: any cell change is one
//   parallel shift, load or clear across all DEPTH cells, with the top and
//   removed words picked by a one-hot select over the cells that same cycle.
//   The response sits in an output register; a new request is taken while
//   that register is empty or being drained in the same cycle. While the
//   receiver stalls, the held response stays put and req.ready is low.
//   Reset empties the stack (count 0) and drops any pending response; the
//   cell words themselves are not cleared, only entries below the count are
//   ever read.
//   Failed requests (full, empty, bad position) leave the stack unchanged and
//   return removed_value 0.
// ----------------------------------------------------------------------------
module integer_stack_with_bottom_ops_unit
	import isbo_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	isbo_req_if.sink   req,
	isbo_rsp_if.source rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned CX = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	status_t       status_q;
	logic [CW-1:0] rsp_count_q;
	word_t         top_q;
	logic          top_valid_q;
	word_t         removed_q;

	logic          fire;
	logic          full;
	logic          empty;
	logic          pos_ok;
	logic [CX-1:0] pos_x;
	logic [CX-1:0] pos_m1;
	logic [CX-1:0] cnt_out_x;

	cell_cmd_t     cmd;
	cell_ctl_t     ctl;
	status_t       status;
	logic [CW-1:0] new_count;
	logic [CW-1:0] from_idx;
	logic [CW-1:0] rm_idx;
	logic          rm_en;
	logic [CW-1:0] top_idx;
	word_t         top_word;
	word_t         rm_word;

	word_t cur_w  [DEPTH];
	word_t next_w [DEPTH];

	assign fire      = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;

	assign full   = (count_q == DEPTH_C);
	assign empty  = (count_q == '0);
	assign pos_x  = CX'(req.position);
	assign pos_m1 = pos_x - CX'(1);
	assign pos_ok = (pos_x != '0) && (pos_x <= CX'(count_q));

	always_comb begin
		cmd       = CMD_HOLD;
		status    = ST_OK;
		new_count = count_q;
		from_idx  = '0;
		rm_idx    = '0;
		rm_en     = 1'b0;
		unique case (req_type_t'(req.req_type))
			REQ_PUSH: begin
				if (full) status = ST_FULL;
				else begin
					cmd       = CMD_WRITE_AT;
					new_count = count_q + CW'(1);
				end
			end
			REQ_POP: begin
				if (empty) status = ST_EMPTY;
				else begin
					new_count = count_q - CW'(1);
					rm_idx    = count_q - CW'(1);
					rm_en     = 1'b1;
				end
			end
			REQ_INSERT: begin
				if (full) status = ST_FULL;
				else begin
					cmd       = CMD_INSERT;
					new_count = count_q + CW'(1);
				end
			end
			REQ_RM_BOTTOM: begin
				if (empty) status = ST_EMPTY;
				else begin
					cmd       = CMD_SHIFT_DOWN;
					new_count = count_q - CW'(1);
					rm_en     = 1'b1;
				end
			end
			REQ_RM_POS: begin
				if (empty) status = ST_EMPTY;
				else if (!pos_ok) status = ST_BADPOS;
				else begin
					cmd       = CMD_SHIFT_DOWN;
					new_count = count_q - CW'(1);
					from_idx  = pos_m1[CW-1:0];
					rm_idx    = pos_m1[CW-1:0];
					rm_en     = 1'b1;
				end
			end
			REQ_ZERO_EVEN: cmd = CMD_ZERO_EVEN;
			default: cmd = CMD_HOLD;
		endcase
	end

	assign ctl.cmd  = fire ? cmd : CMD_HOLD;
	assign ctl.word = req.value;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_w;
		word_t right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cur_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cur_w[i+1];
		end
		isbo_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.from_idx   (from_idx),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cur_w[i]),
			.next_word  (next_w[i])
		);
	end

	// one-hot picks of the new top and the word taken out
	assign top_idx = new_count - CW'(1);

	always_comb begin
		top_word = '0;
		rm_word  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (top_idx == CW'(i)) top_word = top_word | next_w[i];
			if (rm_idx == CW'(i))  rm_word  = rm_word | cur_w[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= new_count;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= status;
			rsp_count_q <= new_count;
			top_valid_q <= (new_count != '0);
			top_q       <= (new_count != '0) ? top_word : '0;
			removed_q   <= rm_en ? rm_word : '0;
		end
	end

	assign cnt_out_x         = CX'(rsp_count_q);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.count         = cnt_out_x[COUNT_W-1:0];
	assign rsp.top_value     = top_q;
	assign rsp.top_valid     = top_valid_q;
	assign rsp.removed_value = removed_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("stack count above depth");

	a_fail_no_removed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q != ST_OK |-> removed_q == '0)
		else $error("failed request returned a removed word");

	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> top_valid_q == (rsp_count_q != '0))
		else $error("top_valid disagrees with count");

	a_fire_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q && rsp_count_q == count_q)
		else $error("accepted request did not produce a response");
`endif

endmodule
